[rtl/hop_payload_tlv_parser_defines.svh]
// Assertion macros shared by the hop payload TLV parser RTL.
// Depends on nothing; every user must have clk and rst_n in scope.
`ifndef HOP_PAYLOAD_TLV_PARSER_DEFINES_SVH
`define HOP_PAYLOAD_TLV_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clk edge outside reset.
`define HPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising clk edge outside reset.
`define HPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HPT_ASSERT_IMP(lbl, ante, cons, msg)
`define HPT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/hpt_pkg.sv]
// Shared types, codes and helper functions of the hop payload TLV parser.
// Depends on nothing; used by every module of the block.
package hpt_pkg;

    // Status codes of a result transaction.
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_BAD_PREFIX  = 4'd1;
    localparam logic [3:0] ST_SHORT_TYPE  = 4'd2;
    localparam logic [3:0] ST_NO_LENGTH   = 4'd3;
    localparam logic [3:0] ST_SHORT_LEN   = 4'd4;
    localparam logic [3:0] ST_OVERRUN     = 4'd5;
    localparam logic [3:0] ST_BAD_AMOUNT  = 4'd6;
    localparam logic [3:0] ST_BAD_CLTV    = 4'd7;
    localparam logic [3:0] ST_BAD_CHANNEL = 4'd8;

    // Configuration register indexes.
    localparam logic [1:0] CFG_AMOUNT  = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_CHANNEL = 2'd2;

    // Kind of the current record.
    localparam logic [1:0] KIND_SKIP    = 2'd0;
    localparam logic [1:0] KIND_AMOUNT  = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_CHANNEL = 2'd3;

    localparam logic [7:0]  BIGSIZE_EXT = 8'd253;
    localparam logic [15:0] AMOUNT_LEN  = 16'd8;
    localparam logic [15:0] TIMEOUT_LEN = 16'd4;
    localparam logic [15:0] CHANNEL_LEN = 16'd8;

    typedef struct packed {
        logic [15:0] amount_code;
        logic [15:0] timeout_code;
        logic [15:0] channel_code;
    } type_codes_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [63:0] amount;
        logic [31:0] timeout_value;
        logic [63:0] channel_id;
    } result_t;

    // The amount code wins over the timeout code, and timeout over channel.
    function automatic logic [1:0] kind_of(input logic [15:0] t, input type_codes_t c);
        logic [1:0] k;
        if (t == c.amount_code)
            k = KIND_AMOUNT;
        else if (t == c.timeout_code)
            k = KIND_TIMEOUT;
        else if (t == c.channel_code)
            k = KIND_CHANNEL;
        else
            k = KIND_SKIP;
        return k;
    endfunction

    // Length check done when a record's value is complete.
    function automatic logic [3:0] length_error(input logic [1:0] k, input logic [15:0] len);
        logic [3:0] e;
        e = ST_OK;
        unique case (k)
            KIND_AMOUNT:  if (len != AMOUNT_LEN)  e = ST_BAD_AMOUNT;
            KIND_TIMEOUT: if (len != TIMEOUT_LEN) e = ST_BAD_CLTV;
            KIND_CHANNEL: if (len != CHANNEL_LEN) e = ST_BAD_CHANNEL;
            default:      e = ST_OK;
        endcase
        return e;
    endfunction

endpackage

[rtl/hop_payload_tlv_parser.sv]
// The last byte of a payload is parsed combinationally as it leaves the input register, and
// its result transaction is presented on the master side from the result register.
// Throughput: one byte per cycle unless stalled; the single parse stage updates once per byte.
// A result waiting on the master side stalls only a following last byte.
// Reset: rst_n is asynchronous and active low; it clears the parse state and both stages
// and restores the type codes to 2, 4 and 6.
//
// Top level of the hop payload TLV parser. Depends on hpt_pkg, hpt_cfg_regs,
// hpt_byte_parser and hop_payload_tlv_parser_defines.svh.
`include "hop_payload_tlv_parser_defines.svh"

module hop_payload_tlv_parser (
    input  logic          clk,
    input  logic          rst_n,
    // Configuration write port.
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_wdata,
    // Byte stream in.
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] byte_value
    input  logic          s_tlast,   // last_byte
    // Result stream out.
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [167:0]  m_tdata    // [3:0] status, [67:4] amount, [99:68] timeout_value,
                                     // [163:100] channel_id, [167:164] zero
);

    hpt_pkg::type_codes_t codes;
    hpt_pkg::result_t     par_res;
    logic                 par_valid;

    // Input register: holds one accepted byte until the parser consumes it.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;
    logic       s_accept;

    // Result register.
    logic             out_valid_reg, out_valid_next;
    hpt_pkg::result_t out_res_reg;

    hpt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .codes     (codes)
    );

    // A byte that is not last moves on freely; a last byte needs room in the result
    // register, which is free when empty or when its transaction completes now.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    hpt_byte_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (advance),
        .byte_value (in_byte_reg),
        .last_byte  (in_last_reg),
        .codes      (codes),
        .res_valid  (par_valid),
        .res        (par_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (par_valid)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (par_valid)
            out_res_reg <= par_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg.channel_id, out_res_reg.timeout_value,
                       out_res_reg.amount, out_res_reg.status};

    `HPT_ASSERT_IMP(a_err_zero, m_tvalid && (m_tdata[3:0] != hpt_pkg::ST_OK), m_tdata[163:4] == 160'd0, "values not cleared on error status")
    `HPT_ASSERT_IMP(a_status_rng, m_tvalid, m_tdata[3:0] <= hpt_pkg::ST_BAD_CHANNEL, "status code out of range")
    `HPT_ASSERT_NXT(a_in_hold, in_valid_reg && !advance, in_valid_reg && $stable(in_byte_reg) && $stable(in_last_reg), "stalled input byte lost")
    `HPT_ASSERT_NXT(a_last_waits, in_valid_reg && in_last_reg && out_valid_reg && !m_tready, in_valid_reg && in_last_reg, "last byte dropped while result stalled")

endmodule

[rtl/hpt_cfg_regs.sv]
// Configuration registers holding the three captured TLV type codes.
// Depends on hpt_pkg for the register indexes and the code struct.
module hpt_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    output hpt_pkg::type_codes_t codes
);

    hpt_pkg::type_codes_t codes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.amount_code  <= 16'd2;
            codes_reg.timeout_code <= 16'd4;
            codes_reg.channel_code <= 16'd6;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                hpt_pkg::CFG_AMOUNT:  codes_reg.amount_code  <= cfg_wdata;
                hpt_pkg::CFG_TIMEOUT: codes_reg.timeout_code <= cfg_wdata;
                hpt_pkg::CFG_CHANNEL: codes_reg.channel_code <= cfg_wdata;
                default:              codes_reg <= codes_reg;
            endcase
        end
    end

    assign codes = codes_reg;

endmodule

[rtl/hpt_byte_parser.sv]
// Parse state of the TLV stream and its one-byte update step.
// Depends on hpt_pkg and on hop_payload_tlv_parser_defines.svh for assertions.
`include "hop_payload_tlv_parser_defines.svh"

module hpt_byte_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           byte_value,
    input  logic                 last_byte,
    input  hpt_pkg::type_codes_t codes,
    output logic                 res_valid,
    output hpt_pkg::result_t     res
);

    localparam logic [2:0] PH_TYPE     = 3'd0;
    localparam logic [2:0] PH_TYPE_EXT = 3'd1;
    localparam logic [2:0] PH_LEN      = 3'd2;
    localparam logic [2:0] PH_LEN_EXT  = 3'd3;
    localparam logic [2:0] PH_VALUE    = 3'd4;
    localparam logic [2:0] PH_ERROR    = 3'd5;

    logic [2:0]  phase_reg,  phase_next;
    logic [1:0]  prefix_reg, prefix_next;
    logic [15:0] type_reg,   type_next;
    logic [15:0] len_reg,    len_next;
    logic [15:0] left_reg,   left_next;
    logic [63:0] amount_reg, amount_next;
    logic [31:0] timeout_reg, timeout_next;
    logic [63:0] channel_reg, channel_next;
    logic [3:0]  err_reg,    err_next;

    logic [1:0]  kind_cur;
    logic        start_req;
    logic        finish_req;
    logic [3:0]  fin_err;
    logic [3:0]  status_v;

    assign kind_cur = hpt_pkg::kind_of(type_reg, codes);

    always_comb
    begin
        phase_next   = phase_reg;
        prefix_next  = prefix_reg;
        type_next    = type_reg;
        len_next     = len_reg;
        left_next    = left_reg;
        amount_next  = amount_reg;
        timeout_next = timeout_reg;
        channel_next = channel_reg;
        err_next     = err_reg;
        start_req    = 1'b0;
        finish_req   = 1'b0;
        fin_err      = hpt_pkg::ST_OK;

        unique case (phase_reg)
            PH_TYPE_EXT:
            begin
                type_next   = {type_reg[7:0], byte_value};
                prefix_next = prefix_reg - 2'd1;
                if (prefix_next == 2'd0)
                    phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                if (byte_value < hpt_pkg::BIGSIZE_EXT)
                begin
                    len_next  = {8'd0, byte_value};
                    start_req = 1'b1;
                end
                else if (byte_value == hpt_pkg::BIGSIZE_EXT)
                begin
                    len_next    = 16'd0;
                    prefix_next = 2'd2;
                    phase_next  = PH_LEN_EXT;
                end
                else
                begin
                    err_next   = hpt_pkg::ST_BAD_PREFIX;
                    phase_next = PH_ERROR;
                end
            end
            PH_LEN_EXT:
            begin
                len_next    = {len_reg[7:0], byte_value};
                prefix_next = prefix_reg - 2'd1;
                if (prefix_next == 2'd0)
                    start_req = 1'b1;
            end
            PH_VALUE:
            begin
                unique case (kind_cur)
                    hpt_pkg::KIND_AMOUNT:  amount_next  = {amount_reg[55:0], byte_value};
                    hpt_pkg::KIND_TIMEOUT: timeout_next = {timeout_reg[23:0], byte_value};
                    hpt_pkg::KIND_CHANNEL: channel_next = {channel_reg[55:0], byte_value};
                    default:               amount_next  = amount_reg;
                endcase
                left_next = left_reg - 16'd1;
                if (left_next == 16'd0)
                    finish_req = 1'b1;
            end
            PH_ERROR:
            begin
                phase_next = PH_ERROR;
            end
            default:
            begin
                // Expecting the first byte of a type.
                if (byte_value < hpt_pkg::BIGSIZE_EXT)
                begin
                    type_next  = {8'd0, byte_value};
                    phase_next = PH_LEN;
                end
                else if (byte_value == hpt_pkg::BIGSIZE_EXT)
                begin
                    type_next   = 16'd0;
                    prefix_next = 2'd2;
                    phase_next  = PH_TYPE_EXT;
                end
                else
                begin
                    err_next   = hpt_pkg::ST_BAD_PREFIX;
                    phase_next = PH_ERROR;
                end
            end
        endcase

        // A zero-length record is finished as soon as its length is known.
        if (start_req)
        begin
            left_next = len_next;
            if (len_next == 16'd0)
                finish_req = 1'b1;
            else
                phase_next = PH_VALUE;
        end

        if (finish_req)
        begin
            fin_err = hpt_pkg::length_error(kind_cur, len_next);
            if (fin_err != hpt_pkg::ST_OK)
            begin
                err_next   = fin_err;
                phase_next = PH_ERROR;
            end
            else
            begin
                phase_next = PH_TYPE;
            end
        end
    end

    // Status of a payload that ends on this byte.
    always_comb
    begin
        status_v = err_next;
        if (err_next == hpt_pkg::ST_OK)
        begin
            unique case (phase_next)
                PH_TYPE_EXT: status_v = hpt_pkg::ST_SHORT_TYPE;
                PH_LEN:      status_v = hpt_pkg::ST_NO_LENGTH;
                PH_LEN_EXT:  status_v = hpt_pkg::ST_SHORT_LEN;
                PH_VALUE:    status_v = hpt_pkg::ST_OVERRUN;
                default:     status_v = hpt_pkg::ST_OK;
            endcase
        end
    end

    assign res_valid         = take & last_byte;
    assign res.status        = status_v;
    assign res.amount        = (status_v == hpt_pkg::ST_OK) ? amount_next  : 64'd0;
    assign res.timeout_value = (status_v == hpt_pkg::ST_OK) ? timeout_next : 32'd0;
    assign res.channel_id    = (status_v == hpt_pkg::ST_OK) ? channel_next : 64'd0;

    // The last byte of a payload returns the parse state to its start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TYPE;
            prefix_reg  <= 2'd0;
            type_reg    <= 16'd0;
            len_reg     <= 16'd0;
            left_reg    <= 16'd0;
            amount_reg  <= 64'd0;
            timeout_reg <= 32'd0;
            channel_reg <= 64'd0;
            err_reg     <= hpt_pkg::ST_OK;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                phase_reg   <= PH_TYPE;
                prefix_reg  <= 2'd0;
                type_reg    <= 16'd0;
                len_reg     <= 16'd0;
                left_reg    <= 16'd0;
                amount_reg  <= 64'd0;
                timeout_reg <= 32'd0;
                channel_reg <= 64'd0;
                err_reg     <= hpt_pkg::ST_OK;
            end
            else
            begin
                phase_reg   <= phase_next;
                prefix_reg  <= prefix_next;
                type_reg    <= type_next;
                len_reg     <= len_next;
                left_reg    <= left_next;
                amount_reg  <= amount_next;
                timeout_reg <= timeout_next;
                channel_reg <= channel_next;
                err_reg     <= err_next;
            end
        end
    end

    `HPT_ASSERT_IMP(a_err_phase, 1'b1, (phase_reg == PH_ERROR) == (err_reg != hpt_pkg::ST_OK), "error code and error phase disagree")
    `HPT_ASSERT_IMP(a_prefix_cnt, (phase_reg == PH_TYPE_EXT) || (phase_reg == PH_LEN_EXT), (prefix_reg == 2'd1) || (prefix_reg == 2'd2), "prefix byte count out of range")
    `HPT_ASSERT_IMP(a_value_left, phase_reg == PH_VALUE, left_reg != 16'd0, "value phase with no bytes left")

endmodule

[test/tb_hop_payload_tlv_parser.sv]
// Self-checking testbench for hop_payload_tlv_parser: payload bytes go in, and each parse
// result is compared against a cycle-free model of the TLV parser kept in a small class.
// Depends on hpt_pkg and the RTL of hop_payload_tlv_parser; it needs no files or arguments.
`timescale 1ns / 100ps

typedef enum logic [2:0] {
    WANT_TYPE,
    TYPE_EXT,
    WANT_LEN,
    LEN_EXT,
    IN_VALUE,
    HALTED
} tlv_phase_t;

// Tracks the payload parse of every accepted byte and holds the results that are still owed.
class payload_tracker_t;
    logic [15:0] amount_code;
    logic [15:0] timeout_code;
    logic [15:0] channel_code;

    tlv_phase_t  phase;
    logic [1:0]  ext_left;
    logic [15:0] rec_type;
    logic [15:0] rec_len;
    logic [15:0] value_left;
    logic [63:0] amount_acc;
    logic [31:0] timeout_acc;
    logic [63:0] channel_acc;
    logic [3:0]  err;

    hpt_pkg::result_t pending_results[$];
    int          failures;
    int          results_checked;
    int          payloads;

    function new();
        amount_code = 16'd2;
        timeout_code = 16'd4;
        channel_code = 16'd6;
        failures = 0;
        results_checked = 0;
        payloads = 0;
        restart();
    endfunction

    function void restart();
        phase = WANT_TYPE;
        ext_left = 2'd0;
        rec_type = 16'd0;
        rec_len = 16'd0;
        value_left = 16'd0;
        amount_acc = 64'd0;
        timeout_acc = 32'd0;
        channel_acc = 64'd0;
        err = hpt_pkg::ST_OK;
    endfunction

    function void abort(logic [3:0] code);
        err = code;
        phase = HALTED;
    endfunction

    // Amount wins over timeout, and timeout over channel, when codes coincide.
    function logic [1:0] record_kind();
        logic [1:0] k;
        if (rec_type == amount_code)
            k = hpt_pkg::KIND_AMOUNT;
        else if (rec_type == timeout_code)
            k = hpt_pkg::KIND_TIMEOUT;
        else if (rec_type == channel_code)
            k = hpt_pkg::KIND_CHANNEL;
        else
            k = hpt_pkg::KIND_SKIP;
        return k;
    endfunction

    function void close_record();
        logic [1:0] k;
        k = record_kind();
        if (k == hpt_pkg::KIND_AMOUNT && rec_len != hpt_pkg::AMOUNT_LEN)
            abort(hpt_pkg::ST_BAD_AMOUNT);
        else if (k == hpt_pkg::KIND_TIMEOUT && rec_len != hpt_pkg::TIMEOUT_LEN)
            abort(hpt_pkg::ST_BAD_CLTV);
        else if (k == hpt_pkg::KIND_CHANNEL && rec_len != hpt_pkg::CHANNEL_LEN)
            abort(hpt_pkg::ST_BAD_CHANNEL);
        else
            phase = WANT_TYPE;
    endfunction

    function void open_value();
        value_left = rec_len;
        if (value_left == 16'd0)
            close_record();
        else
            phase = IN_VALUE;
    endfunction

    // Advances the parse by one accepted byte. Returns 0 when the byte was ignored
    // because an error is already held.
    function bit parse_byte(logic [7:0] b, logic is_last);
        hpt_pkg::result_t r;
        bit      used;
        used = (phase != HALTED);
        case (phase)
            TYPE_EXT:
            begin
                rec_type = {rec_type[7:0], b};
                ext_left = ext_left - 2'd1;
                if (ext_left == 2'd0)
                    phase = WANT_LEN;
            end
            WANT_LEN:
            begin
                if (b < hpt_pkg::BIGSIZE_EXT)
                begin
                    rec_len = {8'd0, b};
                    open_value();
                end
                else if (b == hpt_pkg::BIGSIZE_EXT)
                begin
                    rec_len = 16'd0;
                    ext_left = 2'd2;
                    phase = LEN_EXT;
                end
                else
                    abort(hpt_pkg::ST_BAD_PREFIX);
            end
            LEN_EXT:
            begin
                rec_len = {rec_len[7:0], b};
                ext_left = ext_left - 2'd1;
                if (ext_left == 2'd0)
                    open_value();
            end
            IN_VALUE:
            begin
                case (record_kind())
                    hpt_pkg::KIND_AMOUNT:  amount_acc = {amount_acc[55:0], b};
                    hpt_pkg::KIND_TIMEOUT: timeout_acc = {timeout_acc[23:0], b};
                    hpt_pkg::KIND_CHANNEL: channel_acc = {channel_acc[55:0], b};
                    default: ;
                endcase
                value_left = value_left - 16'd1;
                if (value_left == 16'd0)
                    close_record();
            end
            HALTED: ;
            default:
            begin
                if (b < hpt_pkg::BIGSIZE_EXT)
                begin
                    rec_type = {8'd0, b};
                    phase = WANT_LEN;
                end
                else if (b == hpt_pkg::BIGSIZE_EXT)
                begin
                    rec_type = 16'd0;
                    ext_left = 2'd2;
                    phase = TYPE_EXT;
                end
                else
                    abort(hpt_pkg::ST_BAD_PREFIX);
            end
        endcase
        if (!is_last)
            return used;

        // A payload that stops inside a record reports where it stopped.
        r.status = err;
        if (err == hpt_pkg::ST_OK)
        begin
            case (phase)
                TYPE_EXT: r.status = hpt_pkg::ST_SHORT_TYPE;
                WANT_LEN: r.status = hpt_pkg::ST_NO_LENGTH;
                LEN_EXT:  r.status = hpt_pkg::ST_SHORT_LEN;
                IN_VALUE: r.status = hpt_pkg::ST_OVERRUN;
                default:  r.status = hpt_pkg::ST_OK;
            endcase
        end
        r.amount = (r.status == hpt_pkg::ST_OK) ? amount_acc : 64'd0;
        r.timeout_value = (r.status == hpt_pkg::ST_OK) ? timeout_acc : 32'd0;
        r.channel_id = (r.status == hpt_pkg::ST_OK) ? channel_acc : 64'd0;
        pending_results = {pending_results, r};
        payloads++;
        restart();
        return used;
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
        failures++;
        if (failures <= 10)
            $display("mismatch in %s after %0d results: expected %h, got %h",
                     what, results_checked, want, got);
    endfunction

    function void check_result(logic [167:0] d);
        hpt_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            flag("result with nothing pending, status", 64'd0, {60'd0, d[3:0]});
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (d[3:0] !== want.status)
            flag("status", {60'd0, want.status}, {60'd0, d[3:0]});
        if (d[67:4] !== want.amount)
            flag("amount", want.amount, d[67:4]);
        if (d[99:68] !== want.timeout_value)
            flag("timeout_value", {32'd0, want.timeout_value}, {32'd0, d[99:68]});
        if (d[163:100] !== want.channel_id)
            flag("channel_id", want.channel_id, d[163:100]);
        if (d[167:164] !== 4'd0)
            flag("padding", 64'd0, {60'd0, d[167:164]});
    endfunction
endclass

module tb_hop_payload_tlv_parser;

    // Generous bound for the watchdog on a correct run.
    localparam int CYCLE_LIMIT = 200000;

    // Directed payloads, each entry {last flag, byte}. In order: a bad prefix on its own,
    // a bad prefix followed by an ignored byte, a type extension cut short, a payload that
    // ends before its length, a length extension cut short, a timeout value cut short,
    // a timeout of the wrong length that completes on the last byte, and a timeout record
    // with a non-minimal type and length that parses cleanly.
    localparam logic [8:0] DIRECTED_BYTES [27] = '{
        9'h1FF,
        9'h0FE, 9'h107,
        9'h0FD, 9'h112,
        9'h100,
        9'h000, 9'h0FD, 9'h101,
        9'h004, 9'h003, 9'h1AA,
        9'h004, 9'h003, 9'h0AA, 9'h0BB, 9'h1CC,
        9'h0FD, 9'h000, 9'h004, 9'h0FD, 9'h000, 9'h004,
        9'h001, 9'h002, 9'h003, 9'h104
    };

    logic          clk;
    logic          rst_n = 1'b0;
    logic          cfg_wr_en = 1'b0;
    logic [1:0]    cfg_index = hpt_pkg::CFG_AMOUNT;
    logic [15:0]   cfg_wdata = 16'd0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [7:0]    s_tdata = 8'd0;    // [7:0] byte_value
    logic          s_tlast = 1'b0;    // last_byte
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [167:0]  m_tdata;           // [3:0] status, [67:4] amount, [99:68] timeout_value,
                                      // [163:100] channel_id, [167:164] zero

    payload_tracker_t tracker = new();

    int         sender_idle_pct = 13;
    int         receiver_idle_pct = 50;
    logic       results_held = 1'b0;
    int         bytes_sent = 0;
    int         useful_bytes = 0;
    int         settings_applied = 0;
    int         cycle_count = 0;
    logic [7:0] payload_bytes[$];
    logic [15:0] shared_code;

    hop_payload_tlv_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog. A hang anywhere, including results that never arrive, ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles with %0d results outstanding",
                     cycle_count, tracker.pending_results.size());
            $display("[hop_payload_tlv_parser] ERROR");
            $finish;
        end
    end

    // Result side. Every process samples on the rising edge before any of this edge's
    // nonblocking updates land, so a transaction is seen exactly when both tvalid and
    // tready were high going into the edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
        m_tready <= !results_held && ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // Back-pressure burst: once traffic is under way the result side stops taking
    // transactions for a long stretch. The sender keeps offering bytes, so the parser
    // fills up and must hold off the next last byte.
    initial
    begin
        wait (bytes_sent >= 60);
        @(posedge clk);
        results_held <= 1'b1;
        repeat (400) @(posedge clk);
        results_held <= 1'b0;
    end

    // Offers one byte, with random idle cycles ahead of it, and waits for the transaction.
    // tvalid stays high from one byte to the next unless an idle cycle comes between.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        useful_bytes += tracker.parse_byte(b, is_last);
        bytes_sent++;
    endtask

    // Adds one byte at the end of the payload being built.
    function automatic void append_byte(input logic [7:0] b);
        payload_bytes = {payload_bytes, b};
    endfunction

    // Appends a BigSize. Small values sometimes take the three-byte form on purpose,
    // since the parser accepts a non-minimal encoding.
    function automatic void push_bigsize(input logic [15:0] v);
        if (v < 16'd253 && $urandom_range(0, 3) != 0)
            append_byte(v[7:0]);
        else
        begin
            append_byte(hpt_pkg::BIGSIZE_EXT);
            append_byte(v[15:8]);
            append_byte(v[7:0]);
        end
    endfunction

    // Builds one payload. Most are well-formed records aimed at the configured codes,
    // often repeating a code so that a later record overwrites an earlier value. Some
    // records carry a wrong length, some payloads get a noise byte or are cut short.
    function automatic void compose_payload();
        int          n_rec;
        int          pick;
        int          corrupt;
        int          pos;
        logic [15:0] code;
        logic [15:0] len;
        payload_bytes.delete();
        n_rec = $urandom_range(0, 4);
        for (int r = 0; r < n_rec; r++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
            begin
                code = tracker.amount_code;
                len = hpt_pkg::AMOUNT_LEN;
            end
            else if (pick < 5)
            begin
                code = tracker.timeout_code;
                len = hpt_pkg::TIMEOUT_LEN;
            end
            else if (pick < 7)
            begin
                code = tracker.channel_code;
                len = hpt_pkg::CHANNEL_LEN;
            end
            else
            begin
                code = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 300));
                len = 16'($urandom_range(0, 6));
            end
            if ($urandom_range(0, 9) == 0)
                len = 16'($urandom_range(0, 12));
            else if ($urandom_range(0, 29) == 0)
                len = 16'($urandom_range(253, 280));
            push_bigsize(code);
            push_bigsize(len);
            repeat (len) append_byte(8'($urandom));
        end

        corrupt = $urandom_range(0, 99);
        if (corrupt < 8 && payload_bytes.size() > 0)
        begin
            pos = $urandom_range(0, payload_bytes.size() - 1);
            payload_bytes[pos] = 8'($urandom_range(250, 255));
        end
        else if (corrupt < 20 && payload_bytes.size() > 1)
        begin
            pos = $urandom_range(1, payload_bytes.size() - 1);
            while (payload_bytes.size() > pos)
                void'(payload_bytes.pop_back());
        end
        // A payload always has at least its last byte.
        if (payload_bytes.size() == 0)
            append_byte(8'($urandom));
    endfunction

    // Sends random payloads until the requested number of bytes has gone in.
    task automatic run_random(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            compose_payload();
            foreach (payload_bytes[i])
                send_byte(payload_bytes[i], i == payload_bytes.size() - 1);
        end
        s_tvalid <= 1'b0;
    endtask

    // Waits until every owed result has been seen, then lets the pipeline settle.
    task automatic drain_results();
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Type codes are only rewritten with the parser idle and the byte stream stopped.
    task automatic apply_codes(input logic [15:0] a, input logic [15:0] t, input logic [15:0] c);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= hpt_pkg::CFG_AMOUNT;
        cfg_wdata <= a;
        @(posedge clk);
        cfg_index <= hpt_pkg::CFG_TIMEOUT;
        cfg_wdata <= t;
        @(posedge clk);
        cfg_index <= hpt_pkg::CFG_CHANNEL;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.amount_code = a;
        tracker.timeout_code = t;
        tracker.channel_code = c;
        settings_applied++;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed payloads run on the reset codes 2, 4 and 6; random ones follow at once.
        foreach (DIRECTED_BYTES[i])
            send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
        run_random(130);

        // Extreme codes: zero, all ones, and the BigSize prefix value itself.
        apply_codes(16'd0, 16'hFFFF, 16'd253);
        run_random(130);

        // Now the sender is the slow side.
        sender_idle_pct = 50;
        receiver_idle_pct = 13;
        // All three codes equal: every such record is an amount.
        apply_codes(16'h1234, 16'h1234, 16'h1234);
        run_random(130);

        // Random amount code, with timeout and channel sharing one code.
        shared_code = 16'($urandom);
        apply_codes(16'($urandom), shared_code, shared_code);
        run_random(130);

        // Back to the reset codes with both sides running flat out.
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        apply_codes(16'd2, 16'd4, 16'd6);
        run_random(130);

        drain_results();
        $display("covered %0d bytes (%0d parsed, the rest skipped after an error)",
                 bytes_sent, useful_bytes);
        $display("in %0d payloads under %0d type code settings; %0d results, %0d mismatches",
                 tracker.payloads, settings_applied + 1, tracker.results_checked,
                 tracker.failures);
        if (tracker.failures == 0)
            $display("[hop_payload_tlv_parser] OK");
        else
            $display("[hop_payload_tlv_parser] ERROR");
        $finish;
    end

endmodule
